@@ rtl/core/mdfp_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and the CRC-16 byte update for the frame parser.
// No dependencies; every other file of the parser imports this package.
package mdfp_pkg;

  // Field widths fixed by the frame format and the result layout
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned DIST_W     = 16;
  localparam int unsigned CHAN_W     = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Modbus CRC-16: reflected polynomial, all-ones start value
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Register reset values
  localparam logic [7:0]  DEV_ADDR_RST = 8'd1;
  localparam logic [7:0]  FUNC_RST     = 8'd4;
  localparam logic [15:0] MIN_DIST_RST = 16'd0;
  localparam logic [15:0] MAX_DIST_RST = 16'hFFFF;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEV_ADDR = 2'd0,
    CFG_FUNC     = 2'd1,
    CFG_MIN_DIST = 2'd2,
    CFG_MAX_DIST = 2'd3
  } mdfp_cfg_idx_e;

  // Controller states: byte phases first, then the result drain
  typedef enum logic [3:0] {
    ST_ADDR    = 4'd0,
    ST_FUNC    = 4'd1,
    ST_LEN     = 4'd2,
    ST_PAYLOAD = 4'd3,
    ST_CRC_LO  = 4'd4,
    ST_CRC_HI  = 4'd5,
    ST_RD_HI   = 4'd6,
    ST_RD_LO   = 4'd7,
    ST_EMIT    = 4'd8
  } mdfp_state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic crc_start;  // restart CRC and fold in the current byte
    logic crc_add;    // fold the current byte into the running CRC
    logic cnt_clr;    // clear the payload byte count
    logic pay_wr;     // write the current byte into the payload store
    logic crc_lo_ld;  // capture the received CRC low byte
    logic ch_clr;     // restart the channel counter
    logic rd_lo;      // read the low byte of the current channel word
    logic hi_ld;      // capture the read byte as the high half
    logic out_ld;     // load the output register with a result
    logic ch_inc;     // advance to the next channel
  } mdfp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic addr_match;
    logic func_match;
    logic len_match;
    logic pay_last;
    logic crc_ok;
    logic ch_last;
    logic out_free;
  } mdfp_sts_t;

  // Fold one byte into a Modbus CRC-16, one bit per step
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

@@ rtl/core/mdfp_stream_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channels of the frame parser: received bytes in, channel results out.
// Depends on mdfp_pkg for the field widths.
interface mdfp_byte_if;
  import mdfp_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mdfp_result_if;
  import mdfp_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] channel;
  logic [DIST_W-1:0] distance_cm;
  logic              in_range;
  logic              last;

  modport source (output valid, output channel, output distance_cm, output in_range,
                  output last, input ready);
  modport sink   (input valid, input channel, input distance_cm, input in_range,
                  input last, output ready);
endinterface

@@ rtl/core/mdfp_datapath.sv @@
`timescale 1ns / 1ps
// Datapath of the frame parser: configuration, CRC, payload store, result register.
// Depends on mdfp_pkg and mdfp_result_if; driven by commands from mdfp_ctrl.
module mdfp_datapath import mdfp_pkg::*; #(
  parameter int unsigned PAYLOAD_BYTES = 16,
  parameter int unsigned CHANNELS      = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [BYTE_W-1:0]     rx_byte_i,
  input  mdfp_cmd_t             cmd_i,
  output mdfp_sts_t             sts_o,
  mdfp_result_if.source         res_o
);

  localparam int unsigned AW    = $clog2(PAYLOAD_BYTES);
  localparam int unsigned CNT_W = $clog2(PAYLOAD_BYTES + 1);
  localparam int unsigned CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned IW    = CW + 1;
  localparam int unsigned XW    = ((IW > AW) ? IW : AW) + 1;

  logic [7:0]        dev_addr_q, func_q;
  logic [15:0]       min_q, max_q;
  logic [15:0]       crc_q;
  logic [7:0]        crc_lo_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [CW-1:0]     ch_q;
  logic [BYTE_W-1:0] mem_q [PAYLOAD_BYTES];
  logic [BYTE_W-1:0] rd_q, hi_q;
  logic [IW-1:0]     rd_idx;
  logic [XW-1:0]     rd_x;
  logic              rd_hit;
  logic [DIST_W-1:0] chan_word;
  logic              dist_in_rng;
  logic              out_valid_q;
  logic [CHAN_W-1:0] out_chan_q;
  logic [DIST_W-1:0] out_dist_q;
  logic              out_rng_q, out_last_q;
  logic              out_free;

  // Configuration registers; the low bits of the data go to narrow registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= DEV_ADDR_RST;
      func_q     <= FUNC_RST;
      min_q      <= MIN_DIST_RST;
      max_q      <= MAX_DIST_RST;
    end else if (cfg_we_i) begin
      unique case (mdfp_cfg_idx_e'(cfg_idx_i))
        CFG_DEV_ADDR: dev_addr_q <= cfg_data_i[7:0];
        CFG_FUNC:     func_q     <= cfg_data_i[7:0];
        CFG_MIN_DIST: min_q      <= cfg_data_i;
        CFG_MAX_DIST: max_q      <= cfg_data_i;
      endcase
    end
  end

  // Running CRC, received CRC low byte, payload count and channel counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q    <= CRC_INIT;
      crc_lo_q <= '0;
      cnt_q    <= '0;
      ch_q     <= '0;
    end else begin
      if (cmd_i.crc_start) begin
        crc_q <= crc16_byte(CRC_INIT, rx_byte_i);
      end else if (cmd_i.crc_add) begin
        crc_q <= crc16_byte(crc_q, rx_byte_i);
      end
      if (cmd_i.crc_lo_ld) begin
        crc_lo_q <= rx_byte_i;
      end
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.pay_wr) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (cmd_i.ch_clr) begin
        ch_q <= '0;
      end else if (cmd_i.ch_inc) begin
        ch_q <= ch_q + CW'(1);
      end
    end
  end

  // Payload store: one write port at the byte count, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.pay_wr) begin
      mem_q[cnt_q[AW-1:0]] <= rx_byte_i;
    end
  end

  // Read byte 2*ch or 2*ch+1; bytes past the payload read as zero
  assign rd_idx = {ch_q, cmd_i.rd_lo};
  assign rd_x   = XW'(rd_idx);
  assign rd_hit = rd_x < XW'(PAYLOAD_BYTES);

  always_ff @(posedge clk_i) begin
    rd_q <= rd_hit ? mem_q[rd_x[AW-1:0]] : '0;
    if (cmd_i.hi_ld) begin
      hi_q <= rd_q;
    end
  end

  // Assemble the big-endian word and test it against the open range
  assign chan_word   = {hi_q, rd_q};
  assign dist_in_rng = (chan_word > min_q) && (chan_word < max_q);

  // Output register: loads when empty or being emptied
  assign out_free = !out_valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      out_chan_q <= CHAN_W'(ch_q);
      out_dist_q <= chan_word;
      out_rng_q  <= dist_in_rng;
      out_last_q <= sts_o.ch_last;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.channel     = out_chan_q;
  assign res_o.distance_cm = out_dist_q;
  assign res_o.in_range    = out_rng_q;
  assign res_o.last        = out_last_q;

  // Status for the controller
  assign sts_o.addr_match = rx_byte_i == dev_addr_q;
  assign sts_o.func_match = rx_byte_i == func_q;
  assign sts_o.len_match  = rx_byte_i == BYTE_W'(PAYLOAD_BYTES);
  assign sts_o.pay_last   = cnt_q == CNT_W'(PAYLOAD_BYTES - 1);
  assign sts_o.crc_ok     = {rx_byte_i, crc_lo_q} == crc_q;
  assign sts_o.ch_last    = ch_q == CW'(CHANNELS - 1);
  assign sts_o.out_free   = out_free;

  // Checks
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_ld |-> out_free)
    else $error("result loaded over an untaken result");

  a_store_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pay_wr |-> (cnt_q < CNT_W'(PAYLOAD_BYTES)))
    else $error("payload write past the store");

  a_valid_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.out_ld))
    else $error("result valid without a load");

endmodule

@@ rtl/core/mdfp_ctrl.sv @@
`timescale 1ns / 1ps
// Controller of the frame parser: hunts the frame byte by byte, then drains results.
// Depends on mdfp_pkg; drives mdfp_datapath through command and status structs.
module mdfp_ctrl import mdfp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      rx_valid_i,
  output logic      rx_ready_o,
  input  mdfp_sts_t sts_i,
  output mdfp_cmd_t cmd_o
);

  mdfp_state_e state_q, state_d;
  logic        acc;

  // Take bytes in every frame phase, stall them while results drain
  assign rx_ready_o = (state_q != ST_RD_HI) && (state_q != ST_RD_LO) &&
                      (state_q != ST_EMIT);
  assign acc        = rx_valid_i && rx_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ADDR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_ADDR: begin
        if (acc && sts_i.addr_match) state_d = ST_FUNC;
      end
      ST_FUNC: begin
        if (acc) state_d = sts_i.func_match ? ST_LEN : ST_ADDR;
      end
      ST_LEN: begin
        if (acc) state_d = sts_i.len_match ? ST_PAYLOAD : ST_ADDR;
      end
      ST_PAYLOAD: begin
        if (acc && sts_i.pay_last) state_d = ST_CRC_LO;
      end
      ST_CRC_LO: begin
        if (acc) state_d = ST_CRC_HI;
      end
      ST_CRC_HI: begin
        if (acc) state_d = sts_i.crc_ok ? ST_RD_HI : ST_ADDR;
      end
      ST_RD_HI: state_d = ST_RD_LO;
      ST_RD_LO: state_d = ST_EMIT;
      ST_EMIT: begin
        if (sts_i.out_free) state_d = sts_i.ch_last ? ST_ADDR : ST_RD_HI;
      end
      default: state_d = ST_ADDR;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_ADDR: begin
        cmd_o.crc_start = acc && sts_i.addr_match;
      end
      ST_FUNC: begin
        cmd_o.crc_add = acc && sts_i.func_match;
      end
      ST_LEN: begin
        cmd_o.crc_add = acc && sts_i.len_match;
        cmd_o.cnt_clr = acc && sts_i.len_match;
      end
      ST_PAYLOAD: begin
        cmd_o.pay_wr  = acc;
        cmd_o.crc_add = acc;
      end
      ST_CRC_LO: begin
        cmd_o.crc_lo_ld = acc;
      end
      ST_CRC_HI: begin
        cmd_o.ch_clr = acc;
      end
      ST_RD_HI: begin
        cmd_o.rd_lo = 1'b0;
      end
      ST_RD_LO: begin
        cmd_o.rd_lo = 1'b1;
        cmd_o.hi_ld = 1'b1;
      end
      ST_EMIT: begin
        cmd_o.rd_lo  = 1'b1;
        cmd_o.out_ld = sts_i.out_free;
        cmd_o.ch_inc = sts_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

  // Checks
  a_last_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.out_ld && sts_i.ch_last) |=> (state_q == ST_ADDR))
    else $error("drain did not end after the last channel");

  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && (state_q == ST_PAYLOAD) && !sts_i.pay_last) |=> (state_q == ST_PAYLOAD))
    else $error("payload phase left early");

  a_good_crc_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && (state_q == ST_CRC_HI) && sts_i.crc_ok) |=> !rx_ready_o)
    else $error("byte taken after a good frame before the drain");

endmodule

@@ rtl/core/modbus_distance_frame_parser.sv @@
`timescale 1ns / 1ps
// Each received byte is taken when offered outside the result drain; the frame is checked
// as bytes arrive. After a good CRC high byte the parser emits CHANNELS results, each one
// through RD_HI, RD_LO (two reads of the payload store's read port) and EMIT (one load that
// waits for a free result register); bytes stall in that drain. A bad frame emits nothing.
// Reset (asynchronous, active low) returns to address hunting and loads register
// defaults; the payload store is not cleared and needs no clearing pass.
module modbus_distance_frame_parser import mdfp_pkg::*; #(
  parameter int unsigned PAYLOAD_BYTES = 16,
  parameter int unsigned CHANNELS      = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  mdfp_byte_if.sink             rx_i,
  mdfp_result_if.source         res_o
);

  mdfp_cmd_t cmd;
  mdfp_sts_t sts;
  logic      rx_ready;

  assign rx_i.ready = rx_ready;

  // Frame controller
  mdfp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_i.valid),
    .rx_ready_o (rx_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // CRC, payload store and result register
  mdfp_datapath #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES),
    .CHANNELS      (CHANNELS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .rx_byte_i  (rx_i.rx_byte),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .res_o      (res_o)
  );

endmodule

@@ test/tb_modbus_distance_frame_parser.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for modbus_distance_frame_parser: sends good and broken
// response frames, predicts the channel readings and checks every result item.
// Depends on mdfp_pkg, the stream interfaces and the parser RTL.
module tb_modbus_distance_frame_parser;
  import mdfp_pkg::*;

  localparam int unsigned PAY_N        = 16;
  localparam int unsigned CHAN_N       = 8;
  localparam int unsigned DRAIN_CYCLES = 3 * CHAN_N + 8;
  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned RANDOM_BYTES = 160;
  localparam int unsigned IDLE_PCT     = 9;

  // One channel reading as it leaves the parser
  typedef struct packed {
    logic [CHAN_W-1:0] channel;
    logic [DIST_W-1:0] distance_cm;
    logic              in_range;
    logic              last;
  } reading_t;

  typedef enum logic [3:0] {
    K_CFG, K_GOOD, K_BAD_CRC, K_BAD_FUNC, K_BAD_LEN, K_BAD_ADDR, K_DUP_ADDR, K_TRUNC, K_NOISE
  } step_kind_e;

  // Payload patterns; F_NEAR gives words base-2 .. base+5
  typedef enum logic [1:0] {F_ZERO, F_ONES, F_RAND, F_NEAR} fill_e;

  typedef struct packed {
    step_kind_e    kind;
    mdfp_cfg_idx_e idx;
    logic [15:0]   value;
    fill_e         fill;
    bit            typed;
    int            typ_cnt;
    logic [15:0]   typ_dist;
    logic          typ_inr;
  } plan_row_t;

  // Directed steps; readings are typed in only where they are obvious
  localparam plan_row_t PLAN [27] = '{
    '{K_GOOD,     CFG_DEV_ADDR, 16'h0000, F_ZERO, 1'b1, 8, 16'h0000, 1'b0},
    '{K_GOOD,     CFG_DEV_ADDR, 16'h0000, F_ONES, 1'b1, 8, 16'hFFFF, 1'b0},
    '{K_BAD_CRC,  CFG_DEV_ADDR, 16'h0000, F_ZERO, 1'b1, 0, 16'h0000, 1'b0},
    '{K_GOOD,     CFG_DEV_ADDR, 16'h0000, F_NEAR, 1'b0, 0, 16'h0000, 1'b0},
    '{K_BAD_FUNC, CFG_DEV_ADDR, 16'h0000, F_RAND, 1'b0, 0, 16'h0000, 1'b0},
    '{K_BAD_LEN,  CFG_DEV_ADDR, 16'h0000, F_RAND, 1'b0, 0, 16'h0000, 1'b0},
    '{K_BAD_ADDR, CFG_DEV_ADDR, 16'h0000, F_RAND, 1'b0, 0, 16'h0000, 1'b0},
    '{K_DUP_ADDR, CFG_DEV_ADDR, 16'h0000, F_RAND, 1'b0, 0, 16'h0000, 1'b0},
    '{K_CFG,      CFG_MIN_DIST, 16'h1000, F_ZERO, 1'b0, 0, 16'h0000, 1'b0},
    '{K_CFG,      CFG_MAX_DIST, 16'h1002, F_ZERO, 1'b0, 0, 16'h0000, 1'b0},
    '{K_GOOD,     CFG_DEV_ADDR, 16'h1001, F_NEAR, 1'b0, 0, 16'h0000, 1'b0},
    '{K_CFG,      CFG_MIN_DIST, 16'hFFFF, F_ZERO, 1'b0, 0, 16'h0000, 1'b0},
    '{K_CFG,      CFG_MAX_DIST, 16'hFFFF, F_ZERO, 1'b0, 0, 16'h0000, 1'b0},
    '{K_GOOD,     CFG_DEV_ADDR, 16'h0000, F_ONES, 1'b1, 8, 16'hFFFF, 1'b0},
    '{K_CFG,      CFG_MIN_DIST, 16'h0000, F_ZERO, 1'b0, 0, 16'h0000, 1'b0},
    '{K_CFG,      CFG_MAX_DIST, 16'h0000, F_ZERO, 1'b0, 0, 16'h0000, 1'b0},
    '{K_GOOD,     CFG_DEV_ADDR, 16'h0001, F_NEAR, 1'b0, 0, 16'h0000, 1'b0},
    '{K_CFG,      CFG_DEV_ADDR, 16'h00FF, F_ZERO, 1'b0, 0, 16'h0000, 1'b0},
    '{K_CFG,      CFG_FUNC,     16'h0000, F_ZERO, 1'b0, 0, 16'h0000, 1'b0},
    '{K_GOOD,     CFG_DEV_ADDR, 16'h0000, F_RAND, 1'b0, 0, 16'h0000, 1'b0},
    '{K_CFG,      CFG_DEV_ADDR, 16'h0000, F_ZERO, 1'b0, 0, 16'h0000, 1'b0},
    '{K_CFG,      CFG_FUNC,     16'h00FF, F_ZERO, 1'b0, 0, 16'h0000, 1'b0},
    '{K_GOOD,     CFG_DEV_ADDR, 16'h0000, F_ZERO, 1'b0, 0, 16'h0000, 1'b0},
    '{K_TRUNC,    CFG_DEV_ADDR, 16'h0000, F_RAND, 1'b0, 0, 16'h0000, 1'b0},
    '{K_NOISE,    CFG_DEV_ADDR, 16'h0000, F_RAND, 1'b0, 0, 16'h0000, 1'b0},
    '{K_CFG,      CFG_MAX_DIST, 16'hFFFF, F_ZERO, 1'b0, 0, 16'h0000, 1'b0},
    '{K_GOOD,     CFG_DEV_ADDR, 16'h0000, F_RAND, 1'b0, 0, 16'h0000, 1'b0}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  mdfp_byte_if   rx_bus ();
  mdfp_result_if res_bus ();

  modbus_distance_frame_parser #(
    .PAYLOAD_BYTES (PAY_N),
    .CHANNELS      (CHAN_N)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .rx_i       (rx_bus),
    .res_o      (res_bus)
  );

  // Predictor copy of the registers and the frame state
  logic [7:0]   cfg_addr;
  logic [7:0]   cfg_func;
  logic [15:0]  cfg_min;
  logic [15:0]  cfg_max;
  mdfp_state_e  frame_phase;
  int unsigned  pay_cnt;
  logic [7:0]   pay_mem [PAY_N];
  logic [15:0]  crc_acc;
  logic [7:0]   crc_lo_seen;

  reading_t     readings_due [$];
  reading_t     got_reading;
  reading_t     want_reading;
  bit           typed_on;
  bit           quiet;
  int           hold_req;
  int           hold_seen;
  int           hold_left;
  int unsigned  bytes_sent;
  int unsigned  fail_cnt;
  int unsigned  idle_run;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Fold one byte into the Modbus CRC-16
  function automatic logic [15:0] modbus_crc_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    r = acc ^ {8'h00, b};
    repeat (8) r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
    return r;
  endfunction

  // Advance the predicted frame state by one accepted byte
  task automatic predict_byte(input logic [7:0] b);
    logic [15:0] word;
    case (frame_phase)
      ST_ADDR: begin
        if (b == cfg_addr) begin
          crc_acc     = modbus_crc_step(16'hFFFF, b);
          frame_phase = ST_FUNC;
        end
      end
      ST_FUNC: begin
        if (b == cfg_func) begin
          crc_acc     = modbus_crc_step(crc_acc, b);
          frame_phase = ST_LEN;
        end else begin
          frame_phase = ST_ADDR;
        end
      end
      ST_LEN: begin
        if (b == PAY_N) begin
          crc_acc     = modbus_crc_step(crc_acc, b);
          pay_cnt     = 0;
          frame_phase = ST_PAYLOAD;
        end else begin
          frame_phase = ST_ADDR;
        end
      end
      ST_PAYLOAD: begin
        pay_mem[pay_cnt] = b;
        pay_cnt++;
        crc_acc = modbus_crc_step(crc_acc, b);
        if (pay_cnt >= PAY_N) frame_phase = ST_CRC_LO;
      end
      ST_CRC_LO: begin
        crc_lo_seen = b;
        frame_phase = ST_CRC_HI;
      end
      ST_CRC_HI: begin
        frame_phase = ST_ADDR;
        if ({b, crc_lo_seen} == crc_acc && !typed_on) begin
          for (int i = 0; i < CHAN_N; i++) begin
            word = {pay_mem[2*i], pay_mem[2*i+1]};
            readings_due.push_back('{channel: CHAN_W'(i), distance_cm: word,
                                     in_range: (word > cfg_min) && (word < cfg_max),
                                     last: (i == CHAN_N - 1)});
          end
        end
      end
      default: frame_phase = ST_ADDR;
    endcase
  endtask

  // Offer one byte, with random gaps outside the quiet stretch, and predict on acceptance
  task automatic send_byte(input logic [7:0] b);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      rx_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    rx_bus.valid   <= 1'b1;
    rx_bus.rx_byte <= b;
    do @(posedge clk_i); while (!rx_bus.ready);
    bytes_sent++;
    predict_byte(b);
  endtask

  // Stop sending and wait until every reading has come and the drain is over
  task automatic wait_drained();
    rx_bus.valid <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write one register; narrow registers get junk in the unused upper byte
  task automatic write_reg(input mdfp_cfg_idx_e idx, input logic [15:0] value);
    logic [15:0] data;
    data = value;
    if (idx == CFG_DEV_ADDR || idx == CFG_FUNC) data[15:8] = 8'($urandom_range(0, 255));
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_DEV_ADDR: cfg_addr = value[7:0];
      CFG_FUNC:     cfg_func = value[7:0];
      CFG_MIN_DIST: cfg_min  = value;
      CFG_MAX_DIST: cfg_max  = value;
      default: ;
    endcase
  endtask

  // Build and send a frame (or a broken one, or noise) byte by byte, or write a register
  task automatic run_step(input plan_row_t r);
    logic [7:0]  frame_q [$];
    logic [15:0] w;
    logic [15:0] crc;
    logic [7:0]  addr;
    logic [7:0]  func;
    logic [7:0]  len;
    int          cut;
    if (r.kind == K_CFG) begin
      wait_drained();
      write_reg(r.idx, r.value);
      return;
    end
    addr = cfg_addr;
    func = cfg_func;
    len  = 8'(PAY_N);
    case (r.kind)
      K_BAD_FUNC: func = func ^ 8'($urandom_range(1, 255));
      K_BAD_LEN:  len  = len ^ 8'($urandom_range(1, 255));
      K_BAD_ADDR: addr = addr ^ 8'($urandom_range(1, 255));
      default: ;
    endcase
    frame_q.push_back(addr);
    if (r.kind == K_DUP_ADDR) frame_q.push_back(addr);
    frame_q.push_back(func);
    frame_q.push_back(len);
    crc = modbus_crc_step(16'hFFFF, addr);
    crc = modbus_crc_step(crc, func);
    crc = modbus_crc_step(crc, len);
    for (int i = 0; i < CHAN_N; i++) begin
      case (r.fill)
        F_ZERO:  w = 16'h0000;
        F_ONES:  w = 16'hFFFF;
        F_RAND:  w = 16'($urandom);
        default: w = r.value + 16'(i) - 16'd2;
      endcase
      frame_q.push_back(w[15:8]);
      frame_q.push_back(w[7:0]);
      crc = modbus_crc_step(crc, w[15:8]);
      crc = modbus_crc_step(crc, w[7:0]);
    end
    if (r.kind == K_BAD_CRC) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    frame_q.push_back(crc[7:0]);
    frame_q.push_back(crc[15:8]);
    // Cut a frame short, or replace it with a few stray bytes
    if (r.kind == K_TRUNC) begin
      cut = $urandom_range(1, frame_q.size() - 1);
      while (frame_q.size() > cut) void'(frame_q.pop_back());
    end
    if (r.kind == K_NOISE) begin
      frame_q.delete();
      repeat ($urandom_range(1, 6)) begin
        frame_q.push_back(($urandom_range(0, 2) == 0) ? cfg_addr : 8'($urandom_range(0, 255)));
      end
    end
    typed_on = r.typed;
    foreach (frame_q[k]) send_byte(frame_q[k]);
    if (r.typed) begin
      for (int i = 0; i < r.typ_cnt; i++) begin
        readings_due.push_back('{channel: CHAN_W'(i), distance_cm: r.typ_dist,
                                 in_range: r.typ_inr, last: (i == CHAN_N - 1)});
      end
    end
    typed_on = 1'b0;
  endtask

  // Receiver: random stalls, a long hold-off on request, none in the quiet stretch
  initial begin
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        res_bus.ready <= 1'b0;
        hold_left--;
      end else if (quiet) begin
        res_bus.ready <= 1'b1;
      end else begin
        res_bus.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Compare each result item with the oldest predicted reading
  always @(posedge clk_i) begin
    if (res_bus.valid && res_bus.ready) begin
      got_reading = {res_bus.channel, res_bus.distance_cm, res_bus.in_range, res_bus.last};
      if (readings_due.size() == 0) begin
        $display("%0t: unexpected reading ch %0d dist %h in_range %b last %b", $time,
                 got_reading.channel, got_reading.distance_cm, got_reading.in_range,
                 got_reading.last);
        fail_cnt++;
      end else begin
        want_reading = readings_due.pop_front();
        if (got_reading !== want_reading) begin
          $display("%0t: expected ch %0d dist %h in_range %b last %b, got ch %0d dist %h in_range %b last %b",
                   $time, want_reading.channel, want_reading.distance_cm,
                   want_reading.in_range, want_reading.last, got_reading.channel,
                   got_reading.distance_cm, got_reading.in_range, got_reading.last);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin
    idle_run = 0;
    while (idle_run < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((rx_bus.valid && rx_bus.ready) || (res_bus.valid && res_bus.ready)) begin
        idle_run = 0;
      end else begin
        idle_run++;
      end
    end
    $display("modbus_distance_frame_parser verification failed");
    $finish;
  end

  // Main sequence: reset, directed table, then random frames
  initial begin
    plan_row_t   r;
    int unsigned start_bytes;
    int          frame_no;
    int          roll;
    int          pick;
    logic [15:0] value;
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= CFG_DEV_ADDR;
    cfg_data_i     <= '0;
    rx_bus.valid   <= 1'b0;
    rx_bus.rx_byte <= '0;
    cfg_addr    = DEV_ADDR_RST;
    cfg_func    = FUNC_RST;
    cfg_min     = MIN_DIST_RST;
    cfg_max     = MAX_DIST_RST;
    frame_phase = ST_ADDR;
    pay_cnt     = 0;
    crc_acc     = CRC_INIT;
    crc_lo_seen = 8'h00;
    foreach (pay_mem[k]) pay_mem[k] = 8'h00;
    typed_on   = 1'b0;
    quiet      = 1'b0;
    hold_req   = 0;
    hold_seen  = 0;
    hold_left  = 0;
    bytes_sent = 0;
    fail_cnt   = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (PLAN[k]) run_step(PLAN[k]);

    start_bytes = bytes_sent;
    frame_no    = 0;
    while (bytes_sent - start_bytes < RANDOM_BYTES) begin
      frame_no++;
      quiet = (frame_no >= 5 && frame_no < 9);
      // Hold the receiver off while frames keep coming
      if (frame_no == 3) hold_req++;
      // Pause the sender until every reading is out
      if (frame_no == 5) wait_drained();
      // Now and then move one register to a new setting
      if (frame_no != 3 && frame_no != 4 && $urandom_range(0, 5) == 0) begin
        pick = $urandom_range(0, 3);
        case (mdfp_cfg_idx_e'(pick))
          CFG_DEV_ADDR, CFG_FUNC: value = 16'($urandom_range(0, 255));
          CFG_MIN_DIST: value = 16'($urandom_range(0, 16'h7FFF));
          default:      value = 16'($urandom_range(16'h8000, 16'hFFFF));
        endcase
        if ($urandom_range(0, 4) == 0) value = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
        wait_drained();
        write_reg(mdfp_cfg_idx_e'(pick), value);
      end
      roll = $urandom_range(0, 99);
      if (roll < 65)      r.kind = K_GOOD;
      else if (roll < 71) r.kind = K_BAD_CRC;
      else if (roll < 75) r.kind = K_BAD_FUNC;
      else if (roll < 79) r.kind = K_BAD_LEN;
      else if (roll < 83) r.kind = K_BAD_ADDR;
      else if (roll < 87) r.kind = K_DUP_ADDR;
      else if (roll < 93) r.kind = K_TRUNC;
      else                r.kind = K_NOISE;
      roll = $urandom_range(0, 99);
      if (roll < 50)      r.fill = F_RAND;
      else if (roll < 85) r.fill = F_NEAR;
      else if (roll < 92) r.fill = F_ZERO;
      else                r.fill = F_ONES;
      case ($urandom_range(0, 2))
        0:       r.value = cfg_min;
        1:       r.value = cfg_max;
        default: r.value = 16'($urandom);
      endcase
      r.idx      = CFG_DEV_ADDR;
      r.typed    = 1'b0;
      r.typ_cnt  = 0;
      r.typ_dist = 16'h0000;
      r.typ_inr  = 1'b0;
      run_step(r);
    end
    quiet = 1'b0;

    // Let the last readings drain, then report
    rx_bus.valid <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("modbus_distance_frame_parser verification clean");
    end else begin
      $display("modbus_distance_frame_parser verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/mdfp_pkg.sv
rtl/core/mdfp_stream_if.sv
rtl/core/mdfp_datapath.sv
rtl/core/mdfp_ctrl.sv
rtl/core/modbus_distance_frame_parser.sv
test/tb_modbus_distance_frame_parser.sv
